FILE: src/eas_pkg.sv
// Shared types and constants for the encoder angle and speed front end.
// Holds the register map, the configuration bundle and the microcode word layout.
// No dependencies.
package eas_pkg;

	// Control tick rate, sets the count-to-rpm scale factor
	localparam int CONTROL_RATE_HZ = 20000;
	localparam logic signed [32:0] RATE_K = 33'(CONTROL_RATE_HZ * 60);

	// Register indexes (byte address is 4 times the index)
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_SENSOR_TYPE = 3'd0;
	localparam logic [2:0] REG_POLE_PAIRS  = 3'd1;
	localparam logic [2:0] REG_ELEC_OFS    = 3'd2;
	localparam logic [2:0] REG_LPF_GAIN    = 3'd3;
	localparam logic [2:0] REG_OMEGA_GAIN  = 3'd4;
	localparam logic [2:0] REG_IA_ZERO     = 3'd5;
	localparam logic [2:0] REG_IB_ZERO     = 3'd6;
	localparam logic [2:0] REG_IC_ZERO     = 3'd7;

	// Sensor selector codes
	localparam logic [1:0] SENSOR_HALL  = 2'd0;
	localparam logic [1:0] SENSOR_ENC18 = 2'd1;
	localparam logic [1:0] SENSOR_ENC21 = 2'd2;

	// Branch kinds of a microcode word
	localparam logic [1:0] BR_NEXT = 2'd0; // fall through
	localparam logic [1:0] BR_IDLE = 2'd1; // hold until an item is accepted
	localparam logic [1:0] BR_HALL = 2'd2; // jump to target in hall mode
	localparam logic [1:0] BR_WAIT = 2'd3; // hold while the result is blocked, then jump

	// Multiplier operand selections
	localparam logic [1:0] MS_ANGLE = 2'd0; // mech angle * pole pairs
	localparam logic [1:0] MS_SPEED = 2'd1; // delta * rate scale
	localparam logic [1:0] MS_LPF   = 2'd2; // speed error * lpf gain
	localparam logic [1:0] MS_OMEGA = 2'd3; // filtered speed * omega gain

	typedef struct packed {
		logic [1:0]  sensor_type;
		logic [6:0]  pole_pairs;
		logic [15:0] elec_ofs;
		logic [16:0] lpf_gain;
		logic [31:0] omega_gain;
		logic [11:0] ia_zero;
		logic [11:0] ib_zero;
		logic [11:0] ic_zero;
	} cfg_t;

	typedef struct packed {
		logic [1:0] br;
		logic [3:0] target;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       ld_delta;
		logic       ld_angle;
		logic       ld_elec;
		logic       ld_speed;
		logic       ld_diff;
		logic       ld_filt;
		logic       ld_out;
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic hall;
		logic out_block;
	} stat_t;

endpackage

FILE: src/eas_if.sv
// Item channel interfaces for the encoder angle and speed front end.
// Depends on nothing; valid/ready handshake with source and sink modports.
interface eas_in_if;
	logic        valid;
	logic        ready;
	logic [20:0] raw_angle;
	logic [11:0] ia_sample;
	logic [11:0] ib_sample;
	logic [11:0] ic_sample;

	modport source(output valid, raw_angle, ia_sample, ib_sample, ic_sample, input ready);
	modport sink(input valid, raw_angle, ia_sample, ib_sample, ic_sample, output ready);
endinterface

interface eas_out_if;
	logic               valid;
	logic               ready;
	logic [14:0]        mech_angle;
	logic signed [15:0] elec_angle;
	logic signed [31:0] speed_filtered;
	logic signed [31:0] omega;
	logic signed [12:0] cur_a;
	logic signed [12:0] cur_b;
	logic signed [12:0] cur_c;

	modport source(output valid, mech_angle, elec_angle, speed_filtered, omega,
		cur_a, cur_b, cur_c, input ready);
	modport sink(input valid, mech_angle, elec_angle, speed_filtered, omega,
		cur_a, cur_b, cur_c, output ready);
endinterface

FILE: src/eas_regs.sv
// APB configuration registers of the encoder angle and speed front end.
// Depends on eas_pkg for the register map and cfg_t.
module eas_regs
	import eas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_type <= SENSOR_ENC18;
			cfg_q.pole_pairs  <= 7'd7;
			cfg_q.elec_ofs    <= 16'd0;
			cfg_q.lpf_gain    <= 17'd6554;
			cfg_q.omega_gain  <= 32'd65536;
			cfg_q.ia_zero     <= 12'd2048;
			cfg_q.ib_zero     <= 12'd2048;
			cfg_q.ic_zero     <= 12'd2048;
		end else if (wr) begin
			case (idx)
				REG_SENSOR_TYPE: cfg_q.sensor_type <= pwdata[1:0];
				REG_POLE_PAIRS:  cfg_q.pole_pairs  <= pwdata[6:0];
				REG_ELEC_OFS:    cfg_q.elec_ofs    <= pwdata[15:0];
				REG_LPF_GAIN:    cfg_q.lpf_gain    <= pwdata[16:0];
				REG_OMEGA_GAIN:  cfg_q.omega_gain  <= pwdata;
				REG_IA_ZERO:     cfg_q.ia_zero     <= pwdata[11:0];
				REG_IB_ZERO:     cfg_q.ib_zero     <= pwdata[11:0];
				REG_IC_ZERO:     cfg_q.ic_zero     <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SENSOR_TYPE: prdata = {30'd0, cfg_q.sensor_type};
			REG_POLE_PAIRS:  prdata = {25'd0, cfg_q.pole_pairs};
			REG_ELEC_OFS:    prdata = {16'd0, cfg_q.elec_ofs};
			REG_LPF_GAIN:    prdata = {15'd0, cfg_q.lpf_gain};
			REG_OMEGA_GAIN:  prdata = cfg_q.omega_gain;
			REG_IA_ZERO:     prdata = {20'd0, cfg_q.ia_zero};
			REG_IB_ZERO:     prdata = {20'd0, cfg_q.ib_zero};
			REG_IC_ZERO:     prdata = {20'd0, cfg_q.ic_zero};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

FILE: src/eas_useq.sv
// Microcode sequencer: step counter, control store and branch logic.
// Depends on eas_pkg for ctrl_t, stat_t and the branch codes.
module eas_useq
	import eas_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ANG  = 4'd1;
	localparam logic [3:0] S_ELEC = 4'd2;
	localparam logic [3:0] S_SPD  = 4'd3;
	localparam logic [3:0] S_DIFF = 4'd4;
	localparam logic [3:0] S_FMUL = 4'd5;
	localparam logic [3:0] S_FADD = 4'd6;
	localparam logic [3:0] S_OMUL = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0] step_q;
	logic [3:0] step_d;

	function automatic ctrl_t ucode(input logic [3:0] s);
		ctrl_t w;
		w = '0;
		w.br = BR_NEXT;
		case (s)
			S_IDLE: w.br = BR_IDLE;
			S_ANG: begin
				w.br       = BR_HALL;
				w.target   = S_DIFF;
				w.mul_en   = 1'b1;
				w.mul_sel  = MS_ANGLE;
				w.ld_delta = 1'b1;
				w.ld_angle = 1'b1;
			end
			S_ELEC: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MS_SPEED;
				w.ld_elec = 1'b1;
			end
			S_SPD:  w.ld_speed = 1'b1;
			S_DIFF: w.ld_diff = 1'b1;
			S_FMUL: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MS_LPF;
			end
			S_FADD: w.ld_filt = 1'b1;
			S_OMUL: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MS_OMEGA;
			end
			S_OUT: begin
				w.br     = BR_WAIT;
				w.target = S_IDLE;
				w.ld_out = 1'b1;
			end
			default: w.br = BR_WAIT;
		endcase
		return w;
	endfunction

	assign ctrl = ucode(step_q);

	always_comb begin
		case (ctrl.br)
			BR_IDLE: step_d = stat.start ? step_q + 4'd1 : step_q;
			BR_HALL: step_d = stat.hall ? ctrl.target : step_q + 4'd1;
			BR_WAIT: step_d = stat.out_block ? step_q : ctrl.target;
			default: step_d = step_q + 4'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= S_OUT) else $error("microcode step out of program");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == S_IDLE && stat.start) |=> step_q == S_ANG)
		else $error("accepted item did not start the program");
	a_hall_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == S_ANG && stat.hall) |=> step_q == S_DIFF)
		else $error("hall mode did not skip the angle steps");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == S_OUT && stat.out_block) |=> step_q == S_OUT)
		else $error("result step left while the output was blocked");

endmodule

FILE: src/eas_dp.sv
// Datapath: input latch, shared multiplier, angle/speed/filter state, result register.
// Depends on eas_pkg and the channel interfaces in eas_if.sv; driven by eas_useq.
module eas_dp
	import eas_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  ctrl_t     ctrl,
	output stat_t     stat,
	eas_in_if.sink    in_ch,
	eas_out_if.source out_ch
);

	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

	logic [20:0] raw_q;
	logic [11:0] ia_q, ib_q, ic_q;
	logic [20:0] last_raw_q;
	logic [14:0] held_angle_q;
	logic [15:0] held_elec_q;
	logic signed [31:0] raw_speed_q;
	logic signed [31:0] filt_q;
	logic signed [32:0] op_q;
	logic signed [65:0] prod_q;
	logic               out_valid_q;

	logic        enc18;
	logic        start;
	logic        load_out;
	logic [20:0] cur_w, last_w;
	logic [14:0] mech;
	logic signed [22:0] diff23, half23, rev23, delta23;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [65:0] spd_r, flt_r, flt_s, om_r;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > SAT_HI)
			return 32'sh7FFFFFFF;
		else if (v < SAT_LO)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	assign in_ch.ready    = (ctrl.br == BR_IDLE);
	assign start          = in_ch.valid & in_ch.ready;
	assign stat.start     = start;
	assign stat.hall      = !(cfg.sensor_type == SENSOR_ENC18 ||
		cfg.sensor_type == SENSOR_ENC21);
	assign stat.out_block = out_valid_q & !out_ch.ready;
	assign load_out       = ctrl.ld_out & !stat.out_block;
	assign out_ch.valid   = out_valid_q;

	// angle and wrapped delta
	assign enc18  = (cfg.sensor_type == SENSOR_ENC18);
	assign cur_w  = enc18 ? {3'd0, raw_q[17:0]} : raw_q;
	assign last_w = enc18 ? {3'd0, last_raw_q[17:0]} : last_raw_q;
	assign mech   = enc18 ? raw_q[17:3] : raw_q[20:6];
	assign half23 = enc18 ? 23'sd131072 : 23'sd1048576;
	assign rev23  = enc18 ? 23'sd262144 : 23'sd2097152;
	assign diff23 = $signed({2'b00, cur_w}) - $signed({2'b00, last_w});

	always_comb begin
		if (diff23 > half23)
			delta23 = diff23 - rev23;
		else if (diff23 < -half23)
			delta23 = diff23 + rev23;
		else
			delta23 = diff23;
	end

	// shared multiplier
	always_comb begin
		case (ctrl.mul_sel)
			MS_ANGLE: begin
				mul_a = $signed({18'd0, mech});
				mul_b = $signed({26'd0, cfg.pole_pairs});
			end
			MS_SPEED: begin
				mul_a = op_q;
				mul_b = RATE_K;
			end
			MS_LPF: begin
				mul_a = op_q;
				mul_b = $signed({16'd0, cfg.lpf_gain});
			end
			default: begin
				mul_a = $signed({filt_q[31], filt_q});
				mul_b = $signed({1'b0, cfg.omega_gain});
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// round half up, then floor
	assign spd_r = enc18 ? (prod_q + 66'sd512) >>> 10 : (prod_q + 66'sd4096) >>> 13;
	assign flt_r = (prod_q + 66'sd32768) >>> 16;
	assign flt_s = flt_r + 66'(filt_q);
	assign om_r  = (prod_q + 66'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		if (start) begin
			raw_q <= in_ch.raw_angle;
			ia_q  <= in_ch.ia_sample;
			ib_q  <= in_ch.ib_sample;
			ic_q  <= in_ch.ic_sample;
		end
		if (ctrl.mul_en)
			prod_q <= mul_p;
		if (ctrl.ld_delta)
			op_q <= 33'(delta23);
		else if (ctrl.ld_diff)
			op_q <= 33'(raw_speed_q) - 33'(filt_q);
		if (load_out) begin
			out_ch.mech_angle     <= held_angle_q;
			out_ch.elec_angle     <= held_elec_q;
			out_ch.speed_filtered <= filt_q;
			out_ch.omega          <= sat32(om_r);
			out_ch.cur_a          <= $signed({1'b0, ia_q}) - $signed({1'b0, cfg.ia_zero});
			out_ch.cur_b          <= $signed({1'b0, ib_q}) - $signed({1'b0, cfg.ib_zero});
			out_ch.cur_c          <= $signed({1'b0, ic_q}) - $signed({1'b0, cfg.ic_zero});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q   <= '0;
			held_angle_q <= '0;
			held_elec_q  <= '0;
			raw_speed_q  <= '0;
			filt_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctrl.ld_angle && !stat.hall)
				held_angle_q <= mech;
			if (ctrl.ld_elec)
				held_elec_q <= prod_q[15:0] - cfg.elec_ofs;
			if (ctrl.ld_speed) begin
				raw_speed_q <= sat32(spd_r);
				last_raw_q  <= raw_q;
			end
			if (ctrl.ld_filt)
				filt_q <= sat32(flt_s);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: src/encoder_angle_speed_frontend.sv
// Top level of the encoder angle and speed front end for field-oriented control.
// Depends on eas_pkg, eas_if.sv, eas_regs, eas_useq and eas_dp.
//
// Usage:
//  - in_ch carries one control tick: raw encoder count and three phase current
//    samples. out_ch returns one result item per tick: mechanical and electrical
//    angle, filtered speed (1/256 rpm), omega and the three offset-corrected currents.
//  - The APB port writes the eight configuration registers at byte address 4*index.
//    pready is always high; write only while no item is in flight.
//  - A microcoded program steps a shared multiplier through angle*pole pairs,
//    delta*rate scale, low-pass and omega gain, one product per multiplying step.
//    Hall mode skips the electrical angle and raw speed steps. The next item is
//    accepted only when the program is back in its idle step, so a new item is
//    not taken until the last one has been loaded into the output register.
//  - A finished result sits in the output register; the program parks in its last
//    step while that register is still occupied and the receiver stalls, and
//    resumes as soon as out_ch.ready lets the old result go.
//  - Reset (arst_n low) loads the register defaults, zeroes the angle, speed and
//    filter state, and empties the output register.
module encoder_angle_speed_frontend
	import eas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	eas_in_if.sink            in_ch,
	eas_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t  cfg;
	ctrl_t ctrl;
	stat_t stat;

	// configuration registers
	eas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// step counter and control store
	eas_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// datapath driven by the control word
	eas_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctrl   (ctrl),
		.stat   (stat),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule
